@@ src/wscf_pkg.sv @@
// Package for the wheel speed command framer: widths, frame bytes, segment
// constants and the types shared by the channel interfaces and modules.
// No dependencies.
`default_nettype none

package wscf_pkg;

	localparam int SPEED_W   = 13;
	localparam int CODE_W    = 16;
	localparam int BYTE_W    = 8;
	localparam int MODE_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Fixed frame header
	localparam logic [BYTE_W-1:0] HEAD_ONE = 8'h02;
	localparam logic [BYTE_W-1:0] HEAD_TWO = 8'h09;

	// Segment knee, in 1/16 RPM
	localparam logic [SPEED_W-1:0] SEG_KNEE = 13'd640;

	// Slope numerators; small segments divide by 624, large ones by 1664
	localparam logic [11:0] MUL_POS_SMALL = 12'd796;
	localparam logic [11:0] MUL_NEG_SMALL = 12'd789;
	localparam logic [11:0] MUL_BIG       = 12'd2312;

	// 624 = 16 * 39, 1664 = 128 * 13; reciprocals scaled by 2^22, exact below 2^16
	localparam int                RECIP_SHIFT = 22;
	localparam logic [18:0]       RECIP_39    = 19'd107547;
	localparam logic [18:0]       RECIP_13    = 19'd322639;

	// Segment offsets
	localparam logic [CODE_W-1:0] BASE_POS_SMALL = 16'd70;
	localparam logic [CODE_W-1:0] BASE_POS_BIG   = 16'd888;
	localparam logic [CODE_W-1:0] BASE_NEG_SMALL = 16'd32845;
	localparam logic [CODE_W-1:0] BASE_NEG_BIG   = 16'd33656;

	typedef enum logic [2:0] {
		SEG_ZERO,
		SEG_POS_SMALL,
		SEG_POS_BIG,
		SEG_NEG_SMALL,
		SEG_NEG_BIG
	} wscf_seg_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE_WORD = 2'd0,
		REG_SEND_FULL = 2'd1
	} wscf_reg_t;

	typedef enum logic [3:0] {
		SLOT_HEAD_ONE = 4'd0,
		SLOT_HEAD_TWO = 4'd1,
		SLOT_C1_HI    = 4'd2,
		SLOT_C1_LO    = 4'd3,
		SLOT_C2_HI    = 4'd4,
		SLOT_C2_LO    = 4'd5,
		SLOT_MODE_HI  = 4'd6,
		SLOT_MODE_LO  = 4'd7,
		SLOT_CSUM     = 4'd8
	} wscf_slot_t;

	// Load strobes for the four code pipeline stages
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} wscf_adv_t;

endpackage

`default_nettype wire

@@ src/wscf_in_if.sv @@
// Input request channel: two signed wheel speeds with valid/ready.
// Depends on wscf_pkg.
`default_nettype none

interface wscf_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [wscf_pkg::SPEED_W-1:0]  speed_one;
	logic signed [wscf_pkg::SPEED_W-1:0]  speed_two;

	modport source (output valid, output speed_one, output speed_two, input ready);
	modport sink   (input valid, input speed_one, input speed_two, output ready);
endinterface

`default_nettype wire

@@ src/wscf_out_if.sv @@
// Output byte channel: one frame byte and its end-of-frame flag with valid/ready.
// Depends on wscf_pkg.
`default_nettype none

interface wscf_out_if;
	logic                          valid;
	logic                          ready;
	logic [wscf_pkg::BYTE_W-1:0]   out_byte;
	logic                          last_byte;

	modport source (output valid, output out_byte, output last_byte, input ready);
	modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

@@ src/wscf_cfg_if.sv @@
// Configuration write channel: register index and write data with valid/ready.
// Depends on wscf_pkg.
`default_nettype none

interface wscf_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [wscf_pkg::CFG_IDX_W-1:0]   index;
	logic [wscf_pkg::CFG_DAT_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/wheel_speed_command_framer_unit.sv @@
// Top level of the wheel speed command framer: request pipeline, frame
// buffer, byte serializer and configuration registers.
// Depends on wscf_pkg, wscf_in_if, wscf_out_if, wscf_cfg_if and wscf_code.
`default_nettype none

// Each accepted request (two signed speeds in 1/16 RPM) is turned into two
// 16-bit drive codes and sent out as one command frame, one byte per cycle
// while the sink is ready: 0x02, 0x09, motor one code high/low, motor two
// code high/low, mode word high/low and an additive checksum of the first
// eight bytes. With send_full_frame cleared the frame stops after the mode
// high byte (seven bytes); last_byte marks the final byte either way. The
// one-byte output port sets the rate: a full frame holds nine bytes, a short
// one seven, and with the sink always ready a new request is taken every
// frame. The first byte of a request is presented once it has passed the
// four code stages, the first loaded at acceptance, and then the frame
// buffer. While a frame is being sent up to four more requests are taken
// into the code pipeline; after that the input stalls until the frame
// buffer frees. Write mode_word and send_full_frame only while no frame is
// in flight; they are sampled when a frame is built and while it is sent.
module wheel_speed_command_framer_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wscf_in_if.sink    in_ch,
	wscf_out_if.source out_ch,
	wscf_cfg_if.sink   cfg
);
	import wscf_pkg::*;

	// Configuration registers
	logic [MODE_W-1:0] mode_word_q;
	logic              send_full_q;

	// Code pipeline occupancy
	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;

	// Frame buffer
	logic              busy_q;
	wscf_slot_t        slot_q;
	logic [CODE_W-1:0] c1_q;
	logic [CODE_W-1:0] c2_q;
	logic [BYTE_W-1:0] csum_q;

	wscf_adv_t         adv;
	logic [CODE_W-1:0] code_one;
	logic [CODE_W-1:0] code_two;
	logic              frame_done;
	logic              buf_free;
	logic              load_frame;
	logic [BYTE_W-1:0] csum_d;
	logic              is_last;

	// Configuration writes: always take them, ignore unknown indexes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_word_q <= '0;
			send_full_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			unique case (wscf_reg_t'(cfg.index))
				REG_MODE_WORD: mode_word_q <= cfg.data[MODE_W-1:0];
				REG_SEND_FULL: send_full_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Drop the frame buffer when its last byte is taken; refill it in the same cycle
	assign is_last    = (slot_q == SLOT_CSUM) || (!send_full_q && slot_q == SLOT_MODE_HI);
	assign frame_done = busy_q && out_ch.ready && is_last;
	assign buf_free   = !busy_q || frame_done;
	assign load_frame = vld_s4 && buf_free;

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		adv.ld_s4 = !vld_s4 || buf_free;
		adv.ld_s3 = !vld_s3 || adv.ld_s4;
		adv.ld_s2 = !vld_s2 || adv.ld_s3;
		adv.ld_s1 = !vld_s1 || adv.ld_s2;
	end

	assign in_ch.ready = adv.ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv.ld_s1) vld_s1 <= in_ch.valid;
			if (adv.ld_s2) vld_s2 <= vld_s1;
			if (adv.ld_s3) vld_s3 <= vld_s2;
			if (adv.ld_s4) vld_s4 <= vld_s3;
		end
	end

	wscf_code u_code_one (
		.clk   (clk),
		.adv   (adv),
		.speed (in_ch.speed_one),
		.code  (code_one)
	);

	wscf_code u_code_two (
		.clk   (clk),
		.adv   (adv),
		.speed (in_ch.speed_two),
		.code  (code_two)
	);

	// Checksum over all eight bytes, computed even when the frame is short
	always_comb begin
		csum_d = (HEAD_ONE + HEAD_TWO)
			+ (code_one[15:8] + code_one[7:0])
			+ (code_two[15:8] + code_two[7:0])
			+ (mode_word_q[15:8] + mode_word_q[7:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			slot_q <= SLOT_HEAD_ONE;
		end else if (load_frame) begin
			busy_q <= 1'b1;
			slot_q <= SLOT_HEAD_ONE;
		end else if (frame_done) begin
			busy_q <= 1'b0;
			slot_q <= SLOT_HEAD_ONE;
		end else if (busy_q && out_ch.ready) begin
			slot_q <= wscf_slot_t'(slot_q + 4'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_frame) begin
			c1_q   <= code_one;
			c2_q   <= code_two;
			csum_q <= csum_d;
		end
	end

	// Byte select from the frame buffer
	always_comb begin
		unique case (slot_q)
			SLOT_HEAD_ONE: out_ch.out_byte = HEAD_ONE;
			SLOT_HEAD_TWO: out_ch.out_byte = HEAD_TWO;
			SLOT_C1_HI:    out_ch.out_byte = c1_q[15:8];
			SLOT_C1_LO:    out_ch.out_byte = c1_q[7:0];
			SLOT_C2_HI:    out_ch.out_byte = c2_q[15:8];
			SLOT_C2_LO:    out_ch.out_byte = c2_q[7:0];
			SLOT_MODE_HI:  out_ch.out_byte = mode_word_q[15:8];
			SLOT_MODE_LO:  out_ch.out_byte = mode_word_q[7:0];
			SLOT_CSUM:     out_ch.out_byte = csum_q;
			default:       out_ch.out_byte = '0;
		endcase
	end

	assign out_ch.valid     = busy_q;
	assign out_ch.last_byte = is_last;

`ifndef NO_ASSERTIONS
	// The slot never runs past the end of the selected frame length
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (slot_q <= SLOT_CSUM) && (send_full_q || slot_q <= SLOT_MODE_HI))
		else $error("frame slot beyond end of frame");

	// A new frame starts at the first header byte
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		load_frame |=> busy_q && slot_q == SLOT_HEAD_ONE)
		else $error("frame did not start at header");

	// A finished frame with nothing waiting leaves the buffer empty
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done && !vld_s4 |=> !busy_q)
		else $error("frame buffer still busy after last byte");

	// An accepted request occupies the first stage
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> vld_s1)
		else $error("accepted request lost at stage one");

	// A full last stage never advances while the frame buffer is held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && busy_q && !frame_done |-> !adv.ld_s4)
		else $error("last stage overwritten while frame buffer busy");
`endif

endmodule

`default_nettype wire

@@ src/wscf_code.sv @@
// Speed-to-drive-code datapath: four registered stages (capture, slope
// multiply, reciprocal divide, offset add). Depends on wscf_pkg.
`default_nettype none

module wscf_code (
	input  wire logic                                 clk,
	input  wire wscf_pkg::wscf_adv_t                  adv,
	input  wire logic signed [wscf_pkg::SPEED_W-1:0]  speed,
	output      logic        [wscf_pkg::CODE_W-1:0]   code
);
	import wscf_pkg::*;

	logic signed [SPEED_W-1:0] speed_s1;
	logic [23:0]               prod_s2;
	wscf_seg_t                 seg_s2;
	logic [34:0]               rprod_s3;
	wscf_seg_t                 seg_s3;
	logic [CODE_W-1:0]         code_s4;

	logic              neg;
	logic [12:0]       mag;
	logic              big;
	logic [11:0]       knee_off;
	logic [11:0]       slope;
	wscf_seg_t         seg_d;
	logic              big_s2;
	logic [15:0]       quot_in;
	logic [18:0]       recip;
	logic [12:0]       quot;
	logic [CODE_W-1:0] code_d;

	// Stage 1: magnitude, segment and slope multiply
	always_comb begin
		neg      = speed_s1[SPEED_W-1];
		mag      = neg ? 13'(-speed_s1) : 13'(speed_s1);
		big      = (mag >= SEG_KNEE);
		knee_off = big ? 12'(mag - SEG_KNEE) : 12'(mag);
		slope    = big ? MUL_BIG : (neg ? MUL_NEG_SMALL : MUL_POS_SMALL);
		if (mag == 13'd0) begin
			seg_d = SEG_ZERO;
		end else if (neg) begin
			seg_d = big ? SEG_NEG_BIG : SEG_NEG_SMALL;
		end else begin
			seg_d = big ? SEG_POS_BIG : SEG_POS_SMALL;
		end
	end

	// Stage 2: drop the power-of-two part of the divisor, multiply by reciprocal
	always_comb begin
		big_s2  = (seg_s2 == SEG_POS_BIG) || (seg_s2 == SEG_NEG_BIG);
		quot_in = big_s2 ? prod_s2[22:7] : prod_s2[19:4];
		recip   = big_s2 ? RECIP_13 : RECIP_39;
	end

	// Stage 3: add the segment offset
	always_comb begin
		quot = rprod_s3[34:RECIP_SHIFT];
		unique case (seg_s3)
			SEG_POS_SMALL: code_d = BASE_POS_SMALL + CODE_W'(quot);
			SEG_POS_BIG:   code_d = BASE_POS_BIG + CODE_W'(quot);
			SEG_NEG_SMALL: code_d = BASE_NEG_SMALL + CODE_W'(quot);
			SEG_NEG_BIG:   code_d = BASE_NEG_BIG + CODE_W'(quot);
			default:       code_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s1) begin
			speed_s1 <= speed;
		end
		if (adv.ld_s2) begin
			prod_s2 <= 24'(knee_off) * 24'(slope);
			seg_s2  <= seg_d;
		end
		if (adv.ld_s3) begin
			rprod_s3 <= 35'(quot_in) * 35'(recip);
			seg_s3   <= seg_s2;
		end
		if (adv.ld_s4) begin
			code_s4 <= code_d;
		end
	end

	assign code = code_s4;

endmodule

`default_nettype wire
